FILE: hw/rtl/carp_pkg.sv
// carp_pkg: shared types, codes and constants of the host selection block.
// No dependencies; every other file imports it.

package carp_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned MULT_W = 32;
  localparam int unsigned SCORE_W = HASH_W + MULT_W;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned HIDX_W = 3;
  localparam int unsigned BYTE_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_URL = 2'd2;

  localparam logic [HASH_W-1:0] MIX_CONST = 32'h6253_1965;
  localparam int unsigned URL_ROT = 19;
  localparam int unsigned SCORE_ROT = 21;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic issue;      // read table entry at issue index, push into score pipe
    logic clear_acc;  // start of a scan: forget previous winner
    logic publish;    // move winner into the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;       // score pipe still holds entries
    logic out_free;   // result register can take a new item this cycle
  } dp_stat_t;

  function automatic logic [HASH_W-1:0] rotl32(input logic [HASH_W-1:0] v,
                                               input int unsigned r);
    logic [2*HASH_W-1:0] dbl;
    dbl = {v, v} << r;
    return dbl[2*HASH_W-1:HASH_W];
  endfunction

endpackage

FILE: hw/rtl/carp_req_if.sv
// carp_req_if: input item channel (valid/ready plus item fields).
// Depends on carp_pkg.

interface carp_req_if;
  import carp_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [HIDX_W-1:0] host_index;
  logic [HASH_W-1:0] host_hash_in;
  logic [MULT_W-1:0] host_mult_in;
  logic              host_up_in;
  logic [BYTE_W-1:0] url_byte;
  logic              url_last;

  modport source (
    output valid, func, host_index, host_hash_in, host_mult_in, host_up_in,
           url_byte, url_last,
    input  ready
  );

  modport sink (
    input  valid, func, host_index, host_hash_in, host_mult_in, host_up_in,
           url_byte, url_last,
    output ready
  );
endinterface

FILE: hw/rtl/carp_res_if.sv
// carp_res_if: result item channel (valid/ready plus found flag and host).
// Depends on carp_pkg.

interface carp_res_if;
  import carp_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [HIDX_W-1:0] selected_host;

  modport source (
    output valid, found, selected_host,
    input  ready
  );

  modport sink (
    input  valid, found, selected_host,
    output ready
  );
endinterface

FILE: hw/rtl/carp_host_select.sv
// carp_host_select: routing-hash host selection over a table of HOSTS entries.
// Load, status and non-final URL byte items are accepted whenever the block is idle.
// A final URL byte starts a scan: table reads, one per host, then the score pipe drains
// (read, mix multiply, load multiply, compare) and the winner is published into the
// result register; the next item is taken after the publish, later while a result waits.
// Synchronous reset clears the hash, up flags and entry-loaded flags at once.

module carp_host_select #(
  parameter int unsigned HOSTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  carp_req_if.sink  req,
  carp_res_if.source res
);
  import carp_pkg::*;

  localparam int unsigned IDX_W = (HOSTS > 1) ? $clog2(HOSTS) : 1;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] issue_idx;
  logic             in_fire;

  assign in_fire = req.valid && req.ready;

  carp_ctrl #(
    .HOSTS(HOSTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .func      (req.func),
    .url_last  (req.url_last),
    .in_ready  (req.ready),
    .stat      (stat),
    .cmd       (cmd),
    .issue_idx (issue_idx)
  );

  carp_dpath #(
    .HOSTS(HOSTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .func         (req.func),
    .host_index   (req.host_index),
    .host_hash_in (req.host_hash_in),
    .host_mult_in (req.host_mult_in),
    .host_up_in   (req.host_up_in),
    .url_byte     (req.url_byte),
    .url_last     (req.url_last),
    .cmd          (cmd),
    .issue_idx    (issue_idx),
    .stat         (stat),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .out_found    (res.found),
    .out_host     (res.selected_host)
  );

endmodule

FILE: hw/rtl/carp_ctrl.sv
// carp_ctrl: sequencer for the host scan after a final URL byte.
// Depends on carp_pkg; drives carp_dpath through dp_cmd_t / dp_stat_t.

module carp_ctrl #(
  parameter int unsigned HOSTS = 8,
  localparam int unsigned IDX_W = (HOSTS > 1) ? $clog2(HOSTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [carp_pkg::FUNC_W-1:0] func,
  input  logic                        url_last,
  output logic                        in_ready,
  input  carp_pkg::dp_stat_t          stat,
  output carp_pkg::dp_cmd_t           cmd,
  output logic [IDX_W-1:0]            issue_idx
);
  import carp_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(HOSTS - 1);

  ctl_state_t       state;
  ctl_state_t       state_next;
  logic [IDX_W-1:0] cnt;
  logic             start;

  assign start = (state == ST_IDLE) && in_valid && (func == FUNC_URL) && url_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.issue     = (state == ST_SCAN);
    cmd.clear_acc = start;
    cmd.publish   = (state == ST_DONE) && stat.out_free;
    issue_idx     = cnt;
  end

endmodule

FILE: hw/rtl/carp_dpath.sv
// carp_dpath: host table, running URL hash, score pipeline and winner tracking.
// Depends on carp_pkg; sequenced by carp_ctrl.

module carp_dpath #(
  parameter int unsigned HOSTS = 8,
  localparam int unsigned IDX_W = (HOSTS > 1) ? $clog2(HOSTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic [carp_pkg::FUNC_W-1:0] func,
  input  logic [carp_pkg::HIDX_W-1:0] host_index,
  input  logic [carp_pkg::HASH_W-1:0] host_hash_in,
  input  logic [carp_pkg::MULT_W-1:0] host_mult_in,
  input  logic                        host_up_in,
  input  logic [carp_pkg::BYTE_W-1:0] url_byte,
  input  logic                        url_last,
  input  carp_pkg::dp_cmd_t           cmd,
  input  logic [IDX_W-1:0]            issue_idx,
  output carp_pkg::dp_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [carp_pkg::HIDX_W-1:0] out_host
);
  import carp_pkg::*;

  localparam int unsigned WA_W = (IDX_W > HIDX_W) ? IDX_W : HIDX_W;

  // table memory: {hash, mult} per host; loaded/up bits in flops
  logic [HASH_W+MULT_W-1:0] tab [HOSTS];
  logic [HOSTS-1:0]         loaded;
  logic [HOSTS-1:0]         up;

  logic [WA_W-1:0]   wa_ext;
  logic [IDX_W-1:0]  waddr;
  logic              in_range;
  logic              do_load;
  logic              do_status;
  logic              do_url;

  logic [HASH_W-1:0] url_hash;
  logic [HASH_W-1:0] key;
  logic [HASH_W-1:0] hash_next;

  // score pipe
  logic [HASH_W+MULT_W-1:0] s1_ent;
  logic                     s1_valid, s1_live, s1_loaded;
  logic [IDX_W-1:0]         s1_idx;
  logic [HASH_W-1:0]        s1_x;
  logic [HASH_W-1:0]        s2_mix;
  logic [MULT_W-1:0]        s2_mult;
  logic                     s2_valid, s2_live;
  logic [IDX_W-1:0]         s2_idx;
  logic [SCORE_W-1:0]       s3_prod;
  logic                     s3_valid, s3_live;
  logic [IDX_W-1:0]         s3_idx;

  logic                     found;
  logic [SCORE_W-1:0]       best;
  logic [IDX_W-1:0]         best_idx;
  logic [WA_W-1:0]          best_ext;

  assign wa_ext    = WA_W'(host_index);
  assign waddr     = wa_ext[IDX_W-1:0];
  assign in_range  = (32'(host_index) < HOSTS);
  assign do_load   = in_fire && (func == FUNC_LOAD) && in_range;
  assign do_status = in_fire && (func == FUNC_STATUS) && in_range;
  assign do_url    = in_fire && (func == FUNC_URL);

  assign hash_next = url_hash + rotl32(url_hash, URL_ROT)
                   + {{(HASH_W-BYTE_W){url_byte[BYTE_W-1]}}, url_byte};

  always_ff @(posedge clk) begin
    if (do_load) tab[waddr] <= {host_hash_in, host_mult_in};
    if (cmd.issue) s1_ent <= tab[issue_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      up       <= '0;
      url_hash <= '0;
    end else begin
      if (do_load) loaded[waddr] <= 1'b1;
      if (do_status) up[waddr] <= host_up_in;
      if (do_url) url_hash <= url_last ? '0 : hash_next;
    end
  end

  // hash of the completed URL, held for the scan
  always_ff @(posedge clk) begin
    if (do_url && url_last) key <= hash_next;
  end

  // an entry never loaded reads as zero hash and zero multiplier
  assign s1_x = key ^ (s1_loaded ? s1_ent[HASH_W+MULT_W-1:MULT_W] : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (cmd.clear_acc) begin
        found <= 1'b0;
      end else if (s3_valid && s3_live && (!found || s3_prod > best)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_live   <= up[issue_idx];
    s1_loaded <= loaded[issue_idx];
    s1_idx    <= issue_idx;

    s2_mix  <= s1_x + HASH_W'(s1_x * MIX_CONST);
    s2_mult <= s1_loaded ? s1_ent[MULT_W-1:0] : '0;
    s2_live <= s1_live;
    s2_idx  <= s1_idx;

    s3_prod <= SCORE_W'(rotl32(s2_mix, SCORE_ROT)) * SCORE_W'(s2_mult);
    s3_live <= s2_live;
    s3_idx  <= s2_idx;

    // strict compare keeps the lowest index on ties
    if (s3_valid && s3_live && (!found || s3_prod > best)) begin
      best     <= s3_prod;
      best_idx <= s3_idx;
    end
  end

  assign best_ext = WA_W'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found <= found;
      out_host  <= found ? best_ext[HIDX_W-1:0] : '0;
    end
  end

  assign stat.busy     = s1_valid || s2_valid || s3_valid;
  assign stat.out_free = !out_valid || out_ready;

endmodule

FILE: tb/carp_host_select_checker.sv
`timescale 1ns / 1ps
// carp_host_select_checker: watches the request and result channels, keeps its own
// host table and URL hash, predicts each selection and compares result items in order.
// Depends on carp_pkg, carp_req_if and carp_res_if.

module carp_host_select_checker #(
  parameter int unsigned HOSTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  carp_req_if         req,
  carp_res_if         res,
  output int unsigned errors,
  output int unsigned pending
);
  import carp_pkg::*;

  typedef struct packed {
    logic              found;
    logic [HIDX_W-1:0] host;
  } pick_t;

  logic [HASH_W-1:0] url_acc;
  logic [HASH_W-1:0] tbl_hash [HOSTS];
  logic [MULT_W-1:0] tbl_mult [HOSTS];
  logic              tbl_up   [HOSTS];
  pick_t             picks_due [$];

  function automatic logic [HASH_W-1:0] rot_left(input logic [HASH_W-1:0] v,
                                                 input int unsigned n);
    return (v << n) | (v >> (HASH_W - n));
  endfunction

  // highest score among up hosts; strict compare keeps the lowest index on ties
  function automatic pick_t best_host(input logic [HASH_W-1:0] h);
    pick_t              p;
    logic [SCORE_W-1:0] best;
    logic [SCORE_W-1:0] s;
    logic [HASH_W-1:0]  c;
    p    = '0;
    best = '0;
    for (int k = 0; k < HOSTS; k++) begin
      if (tbl_up[k]) begin
        c = h ^ tbl_hash[k];
        c = c + c * MIX_CONST;
        c = rot_left(c, SCORE_ROT);
        s = SCORE_W'(c) * SCORE_W'(tbl_mult[k]);
        if (!p.found || s > best) begin
          p.found = 1'b1;
          p.host  = HIDX_W'(k);
          best    = s;
        end
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      url_acc = '0;
      for (int k = 0; k < HOSTS; k++) begin
        tbl_hash[k] = '0;
        tbl_mult[k] = '0;
        tbl_up[k]   = 1'b0;
      end
      picks_due.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (picks_due.size() == 0) begin
          $error("result item with no selection pending: found=%0d selected_host=%0d",
                 res.found, res.selected_host);
          errors++;
        end else begin
          want = picks_due.pop_front();
          if (res.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, res.found);
            errors++;
          end
          if (res.selected_host !== want.host) begin
            $error("selected_host: expected %0d, actual %0d", want.host, res.selected_host);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req.func)
          FUNC_LOAD: begin
            if (req.host_index < HOSTS) begin
              tbl_hash[req.host_index] = req.host_hash_in;
              tbl_mult[req.host_index] = req.host_mult_in;
            end
          end
          FUNC_STATUS: begin
            if (req.host_index < HOSTS) tbl_up[req.host_index] = req.host_up_in;
          end
          FUNC_URL: begin
            url_acc = url_acc + rot_left(url_acc, URL_ROT) +
                      {{(HASH_W-BYTE_W){req.url_byte[BYTE_W-1]}}, req.url_byte};
            if (req.url_last) begin
              picks_due = {picks_due, best_host(url_acc)};
              url_acc = '0;
            end
          end
          default: ;
        endcase
      end
      pending = picks_due.size();
    end
  end

endmodule

FILE: tb/carp_host_select_tb.sv
`timescale 1ns / 1ps
// carp_host_select_tb: drives directed and random host-table, URL and noise items into the
// block with random idling on both sides and one long result stall; verdict from the checker.
// Depends on carp_pkg, carp_req_if, carp_res_if, carp_host_select and the checker.

module carp_host_select_tb;
  import carp_pkg::*;

  localparam int unsigned NUM_HOSTS    = 8;
  localparam int unsigned RAND_ITEMS   = 1250;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned err_count;
  int unsigned pending;
  int unsigned rx_stall = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  carp_req_if req_ch ();
  carp_res_if res_ch ();

  carp_host_select #(.HOSTS(NUM_HOSTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  carp_host_select_checker #(.HOSTS(NUM_HOSTS)) chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .errors  (err_count),
    .pending (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[carp_host_select] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // small pools make equal scores between hosts likely
  function automatic logic [HASH_W-1:0] pick_hash();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1234_5678;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MULT_W-1:0] pick_mult();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [HIDX_W-1:0] idx,
                           input logic [HASH_W-1:0] hh, input logic [MULT_W-1:0] mm,
                           input logic up, input logic [BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.func         <= f;
    req_ch.host_index   <= idx;
    req_ch.host_hash_in <= hh;
    req_ch.host_mult_in <= mm;
    req_ch.host_up_in   <= up;
    req_ch.url_byte     <= b;
    req_ch.url_last     <= last;
    req_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_load(input logic [HIDX_W-1:0] idx, input logic [HASH_W-1:0] hh,
                           input logic [MULT_W-1:0] mm);
    send_item(FUNC_LOAD, idx, hh, mm, 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_status(input logic [HIDX_W-1:0] idx, input logic up);
    send_item(FUNC_STATUS, idx, $urandom, $urandom, up, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    send_item(FUNC_URL, 3'($urandom), $urandom, $urandom, 1'($urandom), b, last);
  endtask

  task automatic send_noise();
    send_item(FUNC_NONE, 3'($urandom), $urandom, $urandom, 1'($urandom), 8'($urandom),
              1'($urandom));
  endtask

  // result side: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stall > 0) begin
        res_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) rx_stall = idle_len();
      end
    end
  end

  initial begin
    int unsigned start;
    int unsigned len;
    int unsigned r;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_LOAD;
    req_ch.host_index   = '0;
    req_ch.host_hash_in = '0;
    req_ch.host_mult_in = '0;
    req_ch.host_up_in   = 1'b0;
    req_ch.url_byte     = '0;
    req_ch.url_last     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);                 // nothing up yet
    send_noise();
    send_load(3'd7, '1, '1);                // all-ones hash and multiplier
    send_load(3'd0, '0, '0);
    send_status(3'd0, 1'b1);
    send_status(3'd7, 1'b1);
    send_byte(8'hff, 1'b1);
    send_load(3'd3, '1, '1);                // same entry as host 7
    send_status(3'd3, 1'b1);
    send_byte(8'h00, 1'b1);                 // 3 and 7 tie, 3 should win
    send_load(3'd3, 32'h1234_5678, 32'h0001_0000);  // stays up after load
    send_status(3'd7, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hc3, 1'b1);
    send_load(3'd5, '0, '0);
    send_status(3'd5, 1'b1);
    send_status(3'd3, 1'b0);
    send_byte(8'h5a, 1'b1);                 // 0 and 5 both score zero
    send_status(3'd0, 1'b0);
    send_status(3'd5, 1'b0);
    send_byte(8'h01, 1'b1);                 // all down again

    // random part: mostly whole URLs, with table updates and noise mixed in
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (!hold_req && items_sent - start >= HOLD_AT) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_load(3'($urandom), pick_hash(), pick_mult());
      end else if (r < 22) begin
        send_status(3'($urandom), $urandom_range(0, 3) != 0);
      end else if (r < 25) begin
        send_noise();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          // an occasional table update in the middle of a URL
          if ($urandom_range(0, 19) == 0) send_status(3'($urandom), 1'($urandom));
          send_byte(8'($urandom), k == len - 1);
        end
      end
    end
    req_ch.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("[carp_host_select] OK");
    end else begin
      $display("[carp_host_select] ERROR");
    end
    $finish;
  end

endmodule
